@@ design/smcp_pkg.sv @@
// Shared types and constants of the serial motor command parser.
package smcp_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO_MIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO_MAX    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO_CENTER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 3'd4;

	localparam logic [11:0] SPEED_LIMIT_RST  = 12'd999;
	localparam logic [14:0] SERVO_MIN_RST    = 15'd650;
	localparam logic [14:0] SERVO_MAX_RST    = 15'd2350;
	localparam logic [14:0] SERVO_CENTER_RST = 15'd1500;
	localparam logic [15:0] TIMEOUT_MS_RST   = 16'd500;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result of a line terminator as seen by the parser
	typedef struct packed {
		logic        ok;
		logic        first_neg;
		logic [15:0] first_mag;
		logic        second_neg;
		logic [15:0] second_mag;
	} line_t;

endpackage

@@ design/smcp_if.sv @@
// Handshake channels of the serial motor command parser.
interface smcp_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;
	modport source (output valid, opcode, rx_byte, input ready);
	modport sink (input valid, opcode, rx_byte, output ready);
endinterface

interface smcp_res_if;
	logic        valid;
	logic        ready;
	logic        dir_forward;
	logic        dir_reverse;
	logic [11:0] drive_duty;
	logic [14:0] servo_pulse_us;
	logic        command_accepted;
	logic        timed_out;
	modport source (output valid, dir_forward, dir_reverse, drive_duty, servo_pulse_us,
		command_accepted, timed_out, input ready);
	modport sink (input valid, dir_forward, dir_reverse, drive_duty, servo_pulse_us,
		command_accepted, timed_out, output ready);
endinterface

interface smcp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [smcp_pkg::CFG_IDX_W-1:0]  index;
	logic [smcp_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/smcp_line_parser.sv @@
// Line parser: two signed decimal numbers separated by a comma.
module smcp_line_parser #(
	parameter int unsigned LINE_CHARS = 60
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output smcp_pkg::line_t   line
);
	localparam int unsigned CW = $clog2(LINE_CHARS + 1);

	localparam logic [2:0] PH_LEAD1 = 3'd0;
	localparam logic [2:0] PH_SIGN1 = 3'd1;
	localparam logic [2:0] PH_DIG1  = 3'd2;
	localparam logic [2:0] PH_LEAD2 = 3'd3;
	localparam logic [2:0] PH_SIGN2 = 3'd4;
	localparam logic [2:0] PH_DIG2  = 3'd5;
	localparam logic [2:0] PH_DONE  = 3'd6;
	localparam logic [2:0] PH_FAIL  = 3'd7;

	logic [2:0]    phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic          f_neg_q, f_neg_d, s_neg_q, s_neg_d;
	logic [15:0]   f_mag_q, f_mag_d, s_mag_q, s_mag_d;

	logic        is_term, is_digit, is_sign, is_blank, is_nul, is_minus, has_two;
	logic [15:0] dval, f_acc, s_acc;

	function automatic logic [15:0] add_digit(logic [15:0] mag, logic [15:0] d);
		logic [19:0] v;
		v = {mag, 3'b000} + {1'b0, mag, 1'b0} + {4'd0, d};
		return (v > 20'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	always_comb begin
		is_term  = (rx_byte == 8'h0A) || (rx_byte == 8'h0D);
		is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
		is_minus = (rx_byte == 8'h2D);
		is_sign  = (rx_byte == 8'h2B) || is_minus;
		is_blank = (rx_byte == 8'h20) || (rx_byte == 8'h09) || (rx_byte == 8'h0B)
			|| (rx_byte == 8'h0C);
		is_nul   = (rx_byte == 8'h00);
		dval     = {12'd0, rx_byte[3:0]};
		f_acc    = add_digit(f_mag_q, dval);
		s_acc    = add_digit(s_mag_q, dval);
		has_two  = (phase_q == PH_DIG2) || (phase_q == PH_DONE);

		line.ok         = step && is_term && (count_q != '0) && has_two;
		line.first_neg  = f_neg_q;
		line.first_mag  = f_mag_q;
		line.second_neg = s_neg_q;
		line.second_mag = s_mag_q;
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		f_neg_d = f_neg_q;
		f_mag_d = f_mag_q;
		s_neg_d = s_neg_q;
		s_mag_d = s_mag_q;
		if (is_term) begin
			// Empty line leaves everything alone
			if (count_q != '0) begin
				phase_d = PH_LEAD1;
				count_d = '0;
				f_neg_d = 1'b0;
				s_neg_d = 1'b0;
				f_mag_d = '0;
				s_mag_d = '0;
			end
		end else if (count_q < CW'(LINE_CHARS)) begin
			count_d = count_q + 1'b1;
			if (is_nul) begin
				phase_d = has_two ? PH_DONE : PH_FAIL;
			end else begin
				case (phase_q)
					PH_LEAD1, PH_LEAD2: begin
						if (is_blank) begin
							phase_d = phase_q;
						end else if (is_sign) begin
							if (phase_q == PH_LEAD1) begin
								f_neg_d = is_minus;
								phase_d = PH_SIGN1;
							end else begin
								s_neg_d = is_minus;
								phase_d = PH_SIGN2;
							end
						end else if (is_digit) begin
							if (phase_q == PH_LEAD1) begin
								f_mag_d = dval;
								phase_d = PH_DIG1;
							end else begin
								s_mag_d = dval;
								phase_d = PH_DIG2;
							end
						end else begin
							phase_d = PH_FAIL;
						end
					end
					PH_SIGN1: begin
						if (is_digit) begin
							f_mag_d = dval;
							phase_d = PH_DIG1;
						end else begin
							phase_d = PH_FAIL;
						end
					end
					PH_SIGN2: begin
						if (is_digit) begin
							s_mag_d = dval;
							phase_d = PH_DIG2;
						end else begin
							phase_d = PH_FAIL;
						end
					end
					PH_DIG1: begin
						if (is_digit) begin
							f_mag_d = f_acc;
						end else if (rx_byte == 8'h2C) begin
							phase_d = PH_LEAD2;
						end else begin
							phase_d = PH_FAIL;
						end
					end
					PH_DIG2: begin
						if (is_digit) begin
							s_mag_d = s_acc;
						end else begin
							phase_d = PH_DONE;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD1;
			count_q <= '0;
			f_neg_q <= 1'b0;
			s_neg_q <= 1'b0;
			f_mag_q <= '0;
			s_mag_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			f_neg_q <= f_neg_d;
			s_neg_q <= s_neg_d;
			f_mag_q <= f_mag_d;
			s_mag_q <= s_mag_d;
		end
	end

endmodule

@@ design/serial_motor_command_parser.sv @@
// Top level of the serial motor command parser.
// Takes received bytes and millisecond ticks as command words and returns one result word per
// command word. A word is registered on entry and its result is formed by a single level of
// parse, clamp and idle-count logic into the output register, so one word is taken every cycle
// and its result is presented from the output register; the only limit on rate is the
// result sink holding off the output register. Lines are "speed,pulse" in decimal, ended by CR
// or LF, with only the first LINE_CHARS characters counted. Register writes (index 0
// speed_limit, 1 servo_min, 2 servo_max, 3 servo_center, 4 timeout_ms) are always ready and
// should be made while no word is in flight.
module serial_motor_command_parser #(
	parameter int unsigned LINE_CHARS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	smcp_cmd_if.sink    cmd,
	smcp_cfg_if.sink    cfg,
	smcp_res_if.source  result
);
	logic [11:0] speed_limit_q;
	logic [14:0] servo_min_q, servo_max_q, servo_center_q;
	logic [15:0] timeout_ms_q;

	logic        v_s1;
	logic        opcode_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	logic signed [12:0] speed_q, speed_d, speed_fin;
	logic [14:0]        pulse_q, pulse_d, pulse_fin;
	logic [15:0]        idle_q, idle_d;
	logic               tout;
	logic               spd_neg;
	logic [11:0]        spd_mag, duty;
	logic [14:0]        pulse_out;

	smcp_pkg::line_t line;

	function automatic logic [14:0] clamp_servo(logic [15:0] v, logic [14:0] lo,
		logic [14:0] hi);
		logic [15:0] r;
		r = (v < {1'b0, lo}) ? {1'b0, lo} : v;
		r = (r > {1'b0, hi}) ? {1'b0, hi} : r;
		return r[14:0];
	endfunction

	function automatic logic [11:0] clamp_mag(logic [15:0] m, logic [11:0] lim);
		return (m > {4'd0, lim}) ? lim : m[11:0];
	endfunction

	// Config port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q  <= smcp_pkg::SPEED_LIMIT_RST;
			servo_min_q    <= smcp_pkg::SERVO_MIN_RST;
			servo_max_q    <= smcp_pkg::SERVO_MAX_RST;
			servo_center_q <= smcp_pkg::SERVO_CENTER_RST;
			timeout_ms_q   <= smcp_pkg::TIMEOUT_MS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				smcp_pkg::REG_SPEED_LIMIT:  speed_limit_q  <= cfg.data[11:0];
				smcp_pkg::REG_SERVO_MIN:    servo_min_q    <= cfg.data[14:0];
				smcp_pkg::REG_SERVO_MAX:    servo_max_q    <= cfg.data[14:0];
				smcp_pkg::REG_SERVO_CENTER: servo_center_q <= cfg.data[14:0];
				smcp_pkg::REG_TIMEOUT_MS:   timeout_ms_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register: advance whenever the output register is free or being drained
	assign advance   = !result.valid || result.ready;
	assign cmd.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			opcode_s1 <= cmd.opcode;
			byte_s1   <= cmd.rx_byte;
		end
	end

	smcp_line_parser #(
		.LINE_CHARS (LINE_CHARS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (v_s1 && advance && (opcode_s1 == smcp_pkg::OP_BYTE)),
		.rx_byte (byte_s1),
		.line    (line)
	);

	always_comb begin
		logic [11:0] m;
		m       = '0;
		idle_d  = idle_q;
		speed_d = speed_q;
		pulse_d = pulse_q;
		if (opcode_s1 == smcp_pkg::OP_TICK) begin
			if (idle_q != 16'hFFFF) begin
				idle_d = idle_q + 1'b1;
			end
		end else if (line.ok) begin
			m       = clamp_mag(line.first_mag, speed_limit_q);
			speed_d = line.first_neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
			pulse_d = clamp_servo(line.second_neg ? 16'd0 : line.second_mag,
				servo_min_q, servo_max_q);
			idle_d  = '0;
		end
		tout      = idle_d > timeout_ms_q;
		speed_fin = tout ? '0 : speed_d;
		pulse_fin = tout ? clamp_servo({1'b0, servo_center_q}, servo_min_q, servo_max_q)
			: pulse_d;
		// Re-clamp with the present registers
		spd_neg   = speed_fin[12];
		spd_mag   = spd_neg ? 12'(-speed_fin) : speed_fin[11:0];
		duty      = clamp_mag({4'd0, spd_mag}, speed_limit_q);
		pulse_out = clamp_servo({1'b0, pulse_fin}, servo_min_q, servo_max_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q      <= '0;
			pulse_q      <= smcp_pkg::SERVO_CENTER_RST;
			idle_q       <= '0;
			result.valid <= 1'b0;
		end else if (advance) begin
			result.valid <= v_s1;
			if (v_s1) begin
				speed_q <= speed_fin;
				pulse_q <= pulse_fin;
				idle_q  <= idle_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			result.dir_forward      <= !spd_neg && (duty != '0);
			result.dir_reverse      <= spd_neg && (duty != '0);
			result.drive_duty       <= duty;
			result.servo_pulse_us   <= pulse_out;
			result.command_accepted <= line.ok;
			result.timed_out        <= tout;
		end
	end

endmodule

@@ test/tb_serial_motor_command_parser.sv @@
// Self-checking testbench of the serial motor command parser: directed and random traffic.
`timescale 1ns / 1ps

module tb_serial_motor_command_parser;

	localparam int LINE_LEN     = 60;
	localparam int CLK_PERIOD   = 10;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 500000;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		LN_BLANK1, LN_SIGN1, LN_NUM1, LN_BLANK2, LN_SIGN2, LN_NUM2, LN_END, LN_BAD
	} line_phase_t;

	typedef struct packed {
		logic        fwd;
		logic        rev;
		logic [11:0] duty;
		logic [14:0] pulse;
		logic        accepted;
		logic        timed_out;
	} motor_word_t;

	logic clk = 1'b0;
	logic arst_n;

	smcp_cmd_if cmd_ch();
	smcp_cfg_if cfg_ch();
	smcp_res_if res_ch();

	serial_motor_command_parser #(.LINE_CHARS(LINE_LEN)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.cfg    (cfg_ch),
		.result (res_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Register copies
	int lim_speed, srv_min, srv_max, srv_ctr, tmo_ms;
	// Line parser and drive state
	line_phase_t line_phase;
	int          line_len;
	logic        neg_a, neg_b;
	int          mag_a, mag_b;
	int          speed_now, pulse_now, idle_count;

	motor_word_t outputs_due[$];
	logic [7:0]  line_bytes[$];
	int          words_sent = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          tx_idle_pct = 28;
	int          rx_idle_pct = 80;

	function automatic int servo_clamp(int v);
		if (v < srv_min) v = srv_min;
		if (v > srv_max) v = srv_max;
		return v;
	endfunction

	function automatic int speed_clamp(int v);
		if (v > lim_speed) v = lim_speed;
		if (v < -lim_speed) v = -lim_speed;
		return v;
	endfunction

	function automatic int sat_digit(int m, logic [7:0] c);
		int v;
		v = m * 10 + int'(c - CH_ZERO);
		return (v > 65535) ? 65535 : v;
	endfunction

	function automatic void clear_line();
		line_phase = LN_BLANK1;
		line_len   = 0;
		neg_a      = 1'b0;
		neg_b      = 1'b0;
		mag_a      = 0;
		mag_b      = 0;
	endfunction

	function automatic void scan_char(logic [7:0] c);
		logic digit, sgn, blank;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		sgn   = (c == CH_PLUS) || (c == CH_MINUS);
		blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
		// a zero byte ends the text like a string terminator
		if (c == CH_NUL) begin
			line_phase = (line_phase == LN_NUM2 || line_phase == LN_END) ? LN_END : LN_BAD;
			return;
		end
		case (line_phase)
			LN_BLANK1: begin
				if (blank) ;
				else if (sgn) begin
					neg_a = (c == CH_MINUS);
					line_phase = LN_SIGN1;
				end else if (digit) begin
					mag_a = int'(c - CH_ZERO);
					line_phase = LN_NUM1;
				end else line_phase = LN_BAD;
			end
			LN_SIGN1: begin
				if (digit) begin
					mag_a = int'(c - CH_ZERO);
					line_phase = LN_NUM1;
				end else line_phase = LN_BAD;
			end
			LN_NUM1: begin
				if (digit) mag_a = sat_digit(mag_a, c);
				else if (c == CH_COMMA) line_phase = LN_BLANK2;
				else line_phase = LN_BAD;
			end
			LN_BLANK2: begin
				if (blank) ;
				else if (sgn) begin
					neg_b = (c == CH_MINUS);
					line_phase = LN_SIGN2;
				end else if (digit) begin
					mag_b = int'(c - CH_ZERO);
					line_phase = LN_NUM2;
				end else line_phase = LN_BAD;
			end
			LN_SIGN2: begin
				if (digit) begin
					mag_b = int'(c - CH_ZERO);
					line_phase = LN_NUM2;
				end else line_phase = LN_BAD;
			end
			LN_NUM2: begin
				if (digit) mag_b = sat_digit(mag_b, c);
				else line_phase = LN_END;
			end
			default: ;
		endcase
	endfunction

	// Advance the model by one word and return the outputs it leaves
	function automatic motor_word_t next_outputs(logic op, logic [7:0] c);
		motor_word_t w;
		int spd;
		w.accepted = 1'b0;
		if (op == smcp_pkg::OP_TICK) begin
			if (idle_count < 65535) idle_count++;
		end else if (c == CH_LF || c == CH_CR) begin
			if (line_len > 0) begin
				if (line_phase == LN_NUM2 || line_phase == LN_END) begin
					speed_now  = speed_clamp(neg_a ? -mag_a : mag_a);
					pulse_now  = servo_clamp(neg_b ? -mag_b : mag_b);
					idle_count = 0;
					w.accepted = 1'b1;
				end
				clear_line();
			end
		end else if (line_len < LINE_LEN) begin
			line_len++;
			scan_char(c);
		end
		w.timed_out = (idle_count > tmo_ms);
		if (w.timed_out) begin
			speed_now = 0;
			pulse_now = servo_clamp(srv_ctr);
		end
		// clamp again with the present registers
		spd     = speed_clamp(speed_now);
		w.fwd   = (spd > 0);
		w.rev   = (spd < 0);
		w.duty  = 12'((spd < 0) ? -spd : spd);
		w.pulse = 15'(servo_clamp(pulse_now));
		return w;
	endfunction

	function automatic void apply_reg(logic [smcp_pkg::CFG_IDX_W-1:0] idx,
		logic [smcp_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			smcp_pkg::REG_SPEED_LIMIT:  lim_speed = int'(value[11:0]);
			smcp_pkg::REG_SERVO_MIN:    srv_min   = int'(value[14:0]);
			smcp_pkg::REG_SERVO_MAX:    srv_max   = int'(value[14:0]);
			smcp_pkg::REG_SERVO_CENTER: srv_ctr   = int'(value[14:0]);
			smcp_pkg::REG_TIMEOUT_MS:   tmo_ms    = int'(value);
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ERROR %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// Result checker: compare each word taken against the oldest prediction
	always @(posedge clk) begin : check_results
		motor_word_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (outputs_due.size() == 0) begin
				report_mismatch("result word with nothing outstanding");
			end else begin
				want = outputs_due.pop_front();
				check_field("dir_forward", 16'(res_ch.dir_forward), 16'(want.fwd));
				check_field("dir_reverse", 16'(res_ch.dir_reverse), 16'(want.rev));
				check_field("drive_duty", 16'(res_ch.drive_duty), 16'(want.duty));
				check_field("servo_pulse_us", 16'(res_ch.servo_pulse_us), 16'(want.pulse));
				check_field("command_accepted", 16'(res_ch.command_accepted),
					16'(want.accepted));
				check_field("timed_out", 16'(res_ch.timed_out), 16'(want.timed_out));
			end
		end
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_word(input logic op, input logic [7:0] c);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.opcode  <= op;
		cmd_ch.rx_byte <= c;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		outputs_due.push_back(next_outputs(op, c));
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_word(smcp_pkg::OP_BYTE, s[i]);
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (outputs_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves valid high so back-to-back writes need no lowering in between
	task automatic write_reg(input logic [smcp_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value[smcp_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		apply_reg(idx, value[smcp_pkg::CFG_DATA_W-1:0]);
	endtask

	task automatic set_regs(input int sl, input int lo, input int hi, input int ctr, input int tmo);
		wait_idle();
		write_reg(smcp_pkg::REG_SPEED_LIMIT, sl);
		write_reg(smcp_pkg::REG_SERVO_MIN, lo);
		write_reg(smcp_pkg::REG_SERVO_MAX, hi);
		write_reg(smcp_pkg::REG_SERVO_CENTER, ctr);
		write_reg(smcp_pkg::REG_TIMEOUT_MS, tmo);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_blanks();
		if ($urandom_range(0, 1) == 0) return;
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(0, 3))
				0: line_bytes.push_back(CH_SPACE);
				1: line_bytes.push_back(CH_TAB);
				2: line_bytes.push_back(CH_VT);
				default: line_bytes.push_back(CH_FF);
			endcase
		end
	endtask

	task automatic add_number();
		int n;
		case ($urandom_range(0, 3))
			0: line_bytes.push_back(CH_PLUS);
			1: line_bytes.push_back(CH_MINUS);
			default: ;
		endcase
		// mostly short numbers, a few long enough to saturate
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
		repeat (n) line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic send_random_line();
		int kind;
		kind = $urandom_range(0, 99);
		line_bytes.delete();
		if (kind >= 94) begin
			repeat ($urandom_range(1, 70)) line_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			// pad so the numbers straddle the end of the counted part
			if (kind >= 88) repeat ($urandom_range(40, 66)) line_bytes.push_back(CH_SPACE);
			add_blanks();
			add_number();
			line_bytes.push_back(CH_COMMA);
			add_blanks();
			add_number();
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom_range(32, 126)));
			if (kind >= 82 && kind < 88)
				line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
			else if (kind >= 76 && kind < 82)
				line_bytes[$urandom_range(0, line_bytes.size() - 1)] = CH_NUL;
		end
		foreach (line_bytes[i]) begin
			if ($urandom_range(0, 99) < 6) send_word(smcp_pkg::OP_TICK, 8'($urandom));
			send_word(smcp_pkg::OP_BYTE, line_bytes[i]);
		end
		case ($urandom_range(0, 9))
			0: begin
				send_word(smcp_pkg::OP_BYTE, CH_CR);
				send_word(smcp_pkg::OP_BYTE, CH_LF);
			end
			1, 2, 3, 4: send_word(smcp_pkg::OP_BYTE, CH_CR);
			default: send_word(smcp_pkg::OP_BYTE, CH_LF);
		endcase
	endtask

	task automatic set_random_regs();
		int sl, lo, hi, ctr, tmo;
		case ($urandom_range(0, 3))
			0: sl = 0;
			1: sl = 4095;
			default: sl = $urandom_range(0, 4095);
		endcase
		lo  = $urandom_range(0, 2500);
		hi  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, lo) : $urandom_range(lo, 19999);
		ctr = $urandom_range(0, 19999);
		case ($urandom_range(0, 9))
			0: tmo = 0;
			1: tmo = 65534;
			default: tmo = $urandom_range(1, 40);
		endcase
		set_regs(sl, lo, hi, ctr, tmo);
	endtask

	task automatic test_reset_state();
		send_word(smcp_pkg::OP_TICK, 8'($urandom));
	endtask

	task automatic test_line_forms();
		// saturating first number, explicit plus sign
		send_text("-99999,+7");
		send_word(smcp_pkg::OP_BYTE, CH_LF);
		// tab, vertical tab and form feed blanks, trailing text, CR end
		send_word(smcp_pkg::OP_BYTE, CH_VT);
		send_word(smcp_pkg::OP_BYTE, CH_FF);
		send_text("9,");
		send_word(smcp_pkg::OP_BYTE, CH_TAB);
		send_text("-0x");
		send_word(smcp_pkg::OP_BYTE, CH_CR);
		// empty line
		send_word(smcp_pkg::OP_BYTE, CH_LF);
		// zero byte before the second number: rejected
		send_text("4,");
		send_word(smcp_pkg::OP_BYTE, CH_NUL);
		send_text("2");
		send_word(smcp_pkg::OP_BYTE, CH_LF);
		// zero byte after the second number: accepted
		send_text("3,8");
		send_word(smcp_pkg::OP_BYTE, CH_NUL);
		send_word(smcp_pkg::OP_BYTE, CH_LF);
	endtask

	task automatic test_register_extremes();
		// zero speed limit, servo_min above servo_max, zero timeout
		set_regs(0, 19999, 0, 0, 0);
		send_text("5,5");
		send_word(smcp_pkg::OP_BYTE, CH_LF);
		send_word(smcp_pkg::OP_TICK, 8'($urandom));
		set_regs(4095, 0, 19999, 19999, 65534);
		send_word(smcp_pkg::OP_TICK, 8'($urandom));
		send_text("-5000,30000");
		send_word(smcp_pkg::OP_BYTE, CH_CR);
	endtask

	task automatic test_idle_timeout();
		set_regs(int'(smcp_pkg::SPEED_LIMIT_RST), int'(smcp_pkg::SERVO_MIN_RST),
			int'(smcp_pkg::SERVO_MAX_RST), int'(smcp_pkg::SERVO_CENTER_RST), 5);
		send_text("10,-10");
		send_word(smcp_pkg::OP_BYTE, CH_LF);
		// the sixth tick is the first past the timeout
		repeat (7) send_word(smcp_pkg::OP_TICK, 8'($urandom));
		// a good line clears the idle count
		send_text("-20,2000");
		send_word(smcp_pkg::OP_BYTE, CH_CR);
		send_word(smcp_pkg::OP_TICK, 8'($urandom));
		// the largest timeout is never exceeded
		set_regs(int'(smcp_pkg::SPEED_LIMIT_RST), int'(smcp_pkg::SERVO_MIN_RST),
			int'(smcp_pkg::SERVO_MAX_RST), int'(smcp_pkg::SERVO_CENTER_RST), 65535);
		send_word(smcp_pkg::OP_TICK, 8'($urandom));
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_words);
		int stop_at, next_cfg, cap;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		set_random_regs();
		stop_at  = words_sent + n_words;
		next_cfg = words_sent + 120;
		while (words_sent < stop_at) begin
			if (words_sent >= next_cfg) begin
				set_random_regs();
				next_cfg = words_sent + 120;
			end
			send_random_line();
			cap = (tmo_ms < 57) ? tmo_ms + 3 : 60;
			case ($urandom_range(0, 19))
				0, 1, 2: repeat ($urandom_range(1, cap))
					send_word(smcp_pkg::OP_TICK, 8'($urandom));
				3, 4, 5, 6, 7, 8, 9: repeat ($urandom_range(1, 3))
					send_word(smcp_pkg::OP_TICK, 8'($urandom));
				default: ;
			endcase
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.opcode  = smcp_pkg::OP_BYTE;
		cmd_ch.rx_byte = 8'h00;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = smcp_pkg::REG_SPEED_LIMIT;
		cfg_ch.data    = '0;
		res_ch.ready   = 1'b0;
		lim_speed  = int'(smcp_pkg::SPEED_LIMIT_RST);
		srv_min    = int'(smcp_pkg::SERVO_MIN_RST);
		srv_max    = int'(smcp_pkg::SERVO_MAX_RST);
		srv_ctr    = int'(smcp_pkg::SERVO_CENTER_RST);
		tmo_ms     = int'(smcp_pkg::TIMEOUT_MS_RST);
		clear_line();
		speed_now  = 0;
		pulse_now  = servo_clamp(srv_ctr);
		idle_count = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_line_forms();
		test_register_extremes();
		test_idle_timeout();
		test_random_traffic(28, 80, 325);
		test_random_traffic(80, 28, 325);
		test_random_traffic(0, 0, 325);

		wait_idle();
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/smcp_pkg.sv
design/smcp_if.sv
design/smcp_line_parser.sv
design/serial_motor_command_parser.sv
test/tb_serial_motor_command_parser.sv
